FILE: rtl/rolling_hash_substring_search_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rolling hash substring search
// Each macro expands to a labelled concurrent assertion in simulation and
// to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ROLLING_HASH_SUBSTRING_SEARCH_MACROS_SVH
`define ROLLING_HASH_SUBSTRING_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// Asserts that a condition implies a consequence in the same cycle.
`define RHS_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Asserts that a condition implies a consequence in the next cycle.
`define RHS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`else
`define RHS_ASSERT_IMPL(label, clk, rst_n, cond, cons)
`define RHS_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

FILE: rtl/rhs_pkg.sv
// ---------------------------------------------------------------------------
// Rolling hash search package
// Shared constants and the queue entry type between front and back ends.
// ---------------------------------------------------------------------------
package rhs_pkg;
    localparam int unsigned MAX_PAT      = 16;
    localparam int unsigned PAT_IDX_W    = 4;
    localparam int unsigned LEN_W        = 5;
    localparam int unsigned MOD_W        = 16;
    localparam int unsigned POS_W        = 16;
    localparam logic [15:0] MOD_RESET    = 16'd101;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [1:0] CFG_PAT_LEN  = 2'd2;
    localparam logic [1:0] CFG_MODULUS  = 2'd3;

    // One queued word from the front end to the back end.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       start;
        logic       last;
    } rhs_item_t;

    // Reduces a 24-bit value modulo m by restoring subtraction, one
    // quotient bit at a time; step k tests m << k.
    function automatic logic [23:0] rhs_mod_step(input logic [23:0] r,
                                                 input logic [15:0] m,
                                                 input logic [3:0] k);
        logic [31:0] sh;
        begin
            sh = {16'd0, m} << k;
            if ({8'd0, r} >= sh)
                rhs_mod_step = r - sh[23:0];
            else
                rhs_mod_step = r;
        end
    endfunction
endpackage

FILE: rtl/rhs_queue.sv
// ---------------------------------------------------------------------------
// Rolling hash search item queue
// Two-entry FIFO that decouples byte intake from the hashing engine.
// ---------------------------------------------------------------------------
module rhs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  rhs_pkg::rhs_item_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output rhs_pkg::rhs_item_t rd_data
);
    import rhs_pkg::*;

    rhs_item_t  mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end
endmodule

FILE: rtl/rhs_engine.sv
// ---------------------------------------------------------------------------
// Rolling hash search engine
// Carries out the pattern setup at a text start and the per-byte hash
// update, window shift and exact compare, with a shared serial reducer.
// ---------------------------------------------------------------------------
module rhs_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rhs_pkg::rhs_item_t in_data,
    input  logic [63:0]        pat_low,
    input  logic [63:0]        pat_high,
    input  logic [4:0]         pat_len,
    input  logic [15:0]        modulus,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               res_answer,
    output logic [15:0]        res_position,
    output logic               res_overflow
);
    import rhs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SETUP = 7'b0000010,
        ST_DROP  = 7'b0000100,
        ST_SUB   = 7'b0001000,
        ST_PUSH  = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [23:0] acc_reg, acc_next;
    logic [3:0]  step_reg, step_next;
    logic [4:0]  k_reg, k_next;
    logic        red_reg, red_next;
    logic        lp_reg, lp_next;
    logic [15:0] thash_reg, thash_next;
    logic [15:0] phash_reg, phash_next;
    logic [15:0] lpow_reg, lpow_next;
    logic [15:0] drop_reg, drop_next;
    logic [15:0] pos_reg, pos_next;
    logic [4:0]  fill_reg, fill_next;
    logic        found_reg, found_next;
    logic        ovf_reg, ovf_next;
    logic        open_reg, open_next;
    logic [15:0] mstart_reg, mstart_next;
    logic [4:0]  len_reg, len_next;
    logic [15:0] mod_reg, mod_next;
    logic [7:0]  pat_reg [MAX_PAT];
    logic [7:0]  pat_next [MAX_PAT];
    logic [7:0]  win_reg [MAX_PAT];
    logic [7:0]  win_next [MAX_PAT];
    rhs_item_t   item_reg, item_next;
    logic        ans_reg, ans_next;
    logic        ovalid_reg, ovalid_next;

    logic [7:0]  oldest;
    logic        same;
    logic [4:0]  lim_len;
    logic [15:0] lim_mod;
    logic [7:0]  setup_byte;
    logic [3:0]  kidx;
    logic [4:0]  win_base;

    assign in_ready     = (state_reg == ST_IDLE) && !ovalid_reg;
    assign res_valid    = ovalid_reg;
    assign res_answer   = ans_reg;
    assign res_position = mstart_reg;
    assign res_overflow = ovf_reg;

    // Clamped configuration taken at a text start.
    always_comb
    begin
        lim_len = (pat_len == 5'd0) ? 5'd1 : ((pat_len > 5'd16) ? 5'd16 : pat_len);
        lim_mod = (modulus < 16'd2) ? 16'd2 : modulus;
    end

    // Window entry that leaves, exact compare of window and pattern, and setup byte.
    always_comb
    begin
        win_base = 5'd16 - len_reg;
        oldest   = win_reg[win_base[PAT_IDX_W-1:0]];
        same     = 1'b1;
        for (int i = 0; i < MAX_PAT; i++)
        begin
            if (5'(i) < len_reg)
            begin
                if (win_reg[4'(i) + win_base[PAT_IDX_W-1:0]] != pat_reg[i])
                begin
                    same = 1'b0;
                end
            end
        end
        kidx = k_reg[PAT_IDX_W-1:0];
        setup_byte = (kidx < 4'd8) ? pat_low[{kidx[2:0], 3'b000} +: 8]
                                   : pat_high[{kidx[2:0], 3'b000} +: 8];
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        step_next   = step_reg;
        k_next      = k_reg;
        red_next    = red_reg;
        lp_next     = lp_reg;
        thash_next  = thash_reg;
        phash_next  = phash_reg;
        lpow_next   = lpow_reg;
        drop_next   = drop_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        found_next  = found_reg;
        ovf_next    = ovf_reg;
        open_next   = open_reg;
        mstart_next = mstart_reg;
        len_next    = len_reg;
        mod_next    = mod_reg;
        pat_next    = pat_reg;
        win_next    = win_reg;
        item_next   = item_reg;
        ans_next    = ans_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && res_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next = in_data;
                    if (in_data.start || !open_reg)
                    begin
                        len_next    = lim_len;
                        mod_next    = lim_mod;
                        phash_next  = 16'd0;
                        lpow_next   = 16'd1;
                        thash_next  = 16'd0;
                        pos_next    = 16'd0;
                        fill_next   = 5'd0;
                        found_next  = 1'b0;
                        ovf_next    = 1'b0;
                        mstart_next = 16'd0;
                        open_next   = 1'b1;
                        k_next      = 5'd0;
                        red_next    = 1'b0;
                        lp_next     = 1'b0;
                        for (int i = 0; i < MAX_PAT; i++)
                        begin
                            pat_next[i] = 8'd0;
                        end
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_DROP;
                        red_next   = 1'b0;
                    end
                end
            end
            // Pattern hash and leading power, one pattern byte per round; a
            // round is a hash pass and, for all but the last byte, a power
            // pass, each loading a value then reducing it serially.
            ST_SETUP:
            begin
                if (!red_reg)
                begin
                    if (k_reg == len_reg)
                    begin
                        state_next = ST_DROP;
                    end
                    else if (lp_reg)
                    begin
                        acc_next  = {lpow_reg, 8'd0};
                        step_next = 4'd8;
                        red_next  = 1'b1;
                    end
                    else
                    begin
                        pat_next[kidx] = setup_byte;
                        acc_next  = {phash_reg, 8'd0} + {16'd0, setup_byte};
                        step_next = 4'd8;
                        red_next  = 1'b1;
                    end
                end
                else
                begin
                    acc_next = rhs_mod_step(acc_reg, mod_reg, step_reg);
                    if (step_reg == 4'd0)
                    begin
                        red_next = 1'b0;
                        if (lp_reg)
                        begin
                            lpow_next = acc_next[15:0];
                            lp_next   = 1'b0;
                            k_next    = k_reg + 5'd1;
                        end
                        else
                        begin
                            phash_next = acc_next[15:0];
                            if (k_reg + 5'd1 < len_reg)
                            begin
                                lp_next = 1'b1;
                            end
                            else
                            begin
                                k_next = k_reg + 5'd1;
                            end
                        end
                    end
                    else
                    begin
                        step_next = step_reg - 4'd1;
                    end
                end
            end
            // Byte count, and the hash load while filling or, when full, the
            // dropped term: oldest * leading power, reduced bit-serially.
            ST_DROP:
            begin
                if (!red_reg)
                begin
                    if (pos_reg == 16'hFFFF)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 16'd1;
                    end
                    if (fill_reg < len_reg)
                    begin
                        acc_next  = {thash_reg, 8'd0} + {16'd0, item_reg.text_byte};
                        step_next = 4'd8;
                        red_next  = 1'b1;
                        fill_next = fill_reg + 5'd1;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        acc_next  = {8'd0, lpow_reg} * {16'd0, oldest};
                        step_next = 4'd8;
                        red_next  = 1'b1;
                    end
                end
                else
                begin
                    acc_next = rhs_mod_step(acc_reg, mod_reg, step_reg);
                    if (step_reg == 4'd0)
                    begin
                        drop_next  = acc_next[15:0];
                        red_next   = 1'b0;
                        state_next = ST_SUB;
                    end
                    else
                    begin
                        step_next = step_reg - 4'd1;
                    end
                end
            end
            // Remove the dropped term and shift in the new byte.
            ST_SUB:
            begin
                acc_next = {8'd0, (thash_reg >= drop_reg) ? (thash_reg - drop_reg)
                                  : (thash_reg + mod_reg - drop_reg)};
                acc_next = {acc_next[15:0], 8'd0} + {16'd0, item_reg.text_byte};
                step_next  = 4'd8;
                red_next   = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                acc_next = rhs_mod_step(acc_reg, mod_reg, step_reg);
                if (step_reg == 4'd0)
                begin
                    thash_next = acc_next[15:0];
                    red_next   = 1'b0;
                    for (int i = 0; i < MAX_PAT - 1; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[MAX_PAT-1] = item_reg.text_byte;
                    state_next = ST_CHECK;
                end
                else
                begin
                    step_next = step_reg - 4'd1;
                end
            end
            ST_CHECK:
            begin
                ans_next = 1'b0;
                if (!found_reg && fill_reg == len_reg && thash_reg == phash_reg && same)
                begin
                    found_next  = 1'b1;
                    mstart_next = pos_reg - {11'd0, len_reg} + 16'd1;
                    ans_next    = 1'b1;
                end
                if (item_reg.last)
                begin
                    if (!found_reg && !(fill_reg == len_reg && thash_reg == phash_reg
                                        && same))
                    begin
                        ans_next = 1'b1;
                    end
                    open_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            red_reg    <= 1'b0;
            lp_reg     <= 1'b0;
            thash_reg  <= 16'd0;
            phash_reg  <= 16'd0;
            lpow_reg   <= 16'd1;
            pos_reg    <= 16'd0;
            fill_reg   <= 5'd0;
            found_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            open_reg   <= 1'b0;
            mstart_reg <= 16'd0;
            len_reg    <= 5'd1;
            mod_reg    <= MOD_RESET;
            ovalid_reg <= 1'b0;
            ans_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            red_reg    <= red_next;
            lp_reg     <= lp_next;
            thash_reg  <= thash_next;
            phash_reg  <= phash_next;
            lpow_reg   <= lpow_next;
            pos_reg    <= pos_next;
            fill_reg   <= fill_next;
            found_reg  <= found_next;
            ovf_reg    <= ovf_next;
            open_reg   <= open_next;
            mstart_reg <= mstart_next;
            len_reg    <= len_next;
            mod_reg    <= mod_next;
            ovalid_reg <= ovalid_next;
            ans_reg    <= ans_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        step_reg <= step_next;
        k_reg    <= k_next;
        drop_reg <= drop_next;
        item_reg <= item_next;
        pat_reg  <= pat_next;
        win_reg  <= win_next;
    end
endmodule

FILE: rtl/rolling_hash_substring_search.sv
// One result word per text byte. A byte holds the hashing engine for one
// serial modulo reduction while the window is filling and two once it is
// full (the shared restoring reducer), plus load, subtract, check, output
// and hand-over steps. The first byte of a text adds the setup of the
// pattern hash and the leading power, both produced by the same reducer.
// The engine takes no new byte before the last one's result is out. A result
// that is not taken holds the engine. A two-word queue separates byte
// intake from the engine.
// ---------------------------------------------------------------------------
// Rolling hash substring search
// Finds the first occurrence of a configured pattern in a byte stream.
// ---------------------------------------------------------------------------
`include "rolling_hash_substring_search_macros.svh"
module rolling_hash_substring_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        first_of_text,
    input  logic        last_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        answer_ready,
    output logic [15:0] match_position,
    output logic        position_overflow
);
    import rhs_pkg::*;

    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [4:0]  pat_len_reg;
    logic [15:0] modulus_reg;
    rhs_item_t   q_in, q_out;
    logic        q_valid, q_ready;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= 64'd0;
            pat_high_reg <= 64'd0;
            pat_len_reg  <= 5'd1;
            modulus_reg  <= MOD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_PAT_LEN:  pat_len_reg  <= cfg_data[4:0];
                CFG_MODULUS:  modulus_reg  <= cfg_data[15:0];
            endcase
        end
    end

    assign q_in.text_byte = text_byte;
    assign q_in.start     = first_of_text;
    assign q_in.last      = last_of_text;

    rhs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (q_in),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_out)
    );

    rhs_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_data      (q_out),
        .pat_low      (pat_low_reg),
        .pat_high     (pat_high_reg),
        .pat_len      (pat_len_reg),
        .modulus      (modulus_reg),
        .res_valid    (out_valid),
        .res_ready    (out_ready),
        .res_answer   (answer_ready),
        .res_position (match_position),
        .res_overflow (position_overflow)
    );

    // Checks.
    `RHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `RHS_ASSERT_NEXT(a_ans_stable, clk, rst_n, out_valid && !out_ready, $stable(answer_ready))
    `RHS_ASSERT_NEXT(a_pos_stable, clk, rst_n, out_valid && !out_ready, $stable(match_position))
endmodule

FILE: dv/rolling_hash_substring_search_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rolling hash substring search testbench
// Drives texts through the search block under random flow control, predicts
// every result word from its own model of the search, and compares them.
// ---------------------------------------------------------------------------
module rolling_hash_substring_search_tb;
    import rhs_pkg::*;

    localparam int unsigned TEXT_LIMIT = 65535;
    localparam int unsigned CYCLE_LIMIT = 1500000;

    // One predicted result word.
    typedef struct {
        logic        hit;
        logic [15:0] pos;
        logic        ovf;
    } answer_t;

    // Scoreboard holding a model of the search and the answers still owed.
    class search_scoreboard;
        logic [63:0] reg_low, reg_high;
        logic [4:0]  reg_len;
        logic [15:0] reg_mod;
        logic [7:0]  win [MAX_PAT];
        logic [7:0]  pat [MAX_PAT];
        int unsigned thash, phash, lpow, nbytes, fill, plen, pmod, start_pos;
        bit          found, ovf, open;
        answer_t     owed [$];
        int          mismatches;

        function void clear();
            reg_low = '0;
            reg_high = '0;
            reg_len = 5'd1;
            reg_mod = MOD_RESET;
            open = 0;
            owed.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                CFG_PAT_LOW:  reg_low = value;
                CFG_PAT_HIGH: reg_high = value;
                CFG_PAT_LEN:  reg_len = value[4:0];
                CFG_MODULUS:  reg_mod = value[15:0];
                default: ;
            endcase
        endfunction

        // Latches the pattern and derives its hash and the leading power.
        function void open_text();
            plen = (reg_len == 0) ? 1 : (reg_len > MAX_PAT) ? MAX_PAT : reg_len;
            pmod = (reg_mod < 2) ? 2 : reg_mod;
            phash = 0;
            lpow = 1;
            for (int k = 0; k < MAX_PAT; k++)
            begin
                pat[k] = (k >= plen) ? 8'd0 : (k < 8) ? reg_low[8*k +: 8]
                                                      : reg_high[8*(k-8) +: 8];
                if (k < plen)
                    phash = (phash * 256 + pat[k]) % pmod;
                if (k + 1 < plen)
                    lpow = (lpow * 256) % pmod;
                win[k] = 8'd0;
            end
            thash = 0;
            nbytes = 0;
            fill = 0;
            found = 0;
            ovf = 0;
            start_pos = 0;
            open = 1;
        endfunction

        // Notes an accepted text word and queues the answer it causes.
        function void note_word(logic [7:0] b, logic first, logic last);
            answer_t a;
            bit same;
            a.hit = 0;
            if (first || !open)
                open_text();
            if (nbytes >= TEXT_LIMIT)
                ovf = 1;
            else
                nbytes++;
            if (fill < plen)
            begin
                thash = (thash * 256 + b) % pmod;
                fill++;
            end
            else
            begin
                thash = (thash + pmod - (win[MAX_PAT - plen] * lpow) % pmod) % pmod;
                thash = (thash * 256 + b) % pmod;
            end
            for (int k = 0; k < MAX_PAT - 1; k++)
                win[k] = win[k + 1];
            win[MAX_PAT - 1] = b;
            if (!found && fill == plen && thash == phash)
            begin
                same = 1;
                for (int k = 0; k < plen; k++)
                    if (win[MAX_PAT - plen + k] != pat[k])
                        same = 0;
                if (same)
                begin
                    found = 1;
                    start_pos = nbytes - plen + 1;
                    a.hit = 1;
                end
            end
            if (last)
            begin
                if (!found)
                    a.hit = 1;
                open = 0;
            end
            a.pos = start_pos[15:0];
            a.ovf = ovf;
            owed.push_back(a);
        endfunction

        function void check_answer(logic hit, logic [15:0] pos, logic ovf_bit);
            answer_t e;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: hit %0b pos %0d", hit, pos);
                return;
            end
            e = owed.pop_front();
            if (hit !== e.hit || pos !== e.pos || ovf_bit !== e.ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %0b/%0d/%0b got %0b/%0d/%0b",
                             e.hit, e.pos, e.ovf, hit, pos, ovf_bit);
            end
        endfunction
    endclass

    logic        clk = 0, rst_n = 0;
    logic        cfg_valid = 0, cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 0, in_ready;
    logic [7:0]  text_byte = '0;
    logic        first_of_text = 0, last_of_text = 0;
    logic        out_valid, out_ready = 0;
    logic        answer_ready, position_overflow;
    logic [15:0] match_position;

    search_scoreboard sb = new();
    int unsigned cycles = 0;
    bit          hold_off = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    rolling_hash_substring_search DUT (.*);

    function automatic int unsigned gap_len();
        int unsigned r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rolling_hash_substring_search verification failed");
            $finish;
        end
    end

    // Receiver: random stalls plus one long hold-off on request.
    initial
    begin
        int unsigned g;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0)
            begin
                out_ready <= 0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_answer(answer_ready, match_position, position_overflow);
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [63:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
        cfg_valid <= 0;
    endtask

    task automatic send_word(logic [7:0] b, logic first, logic last, bit paced);
        int unsigned g = paced ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        text_byte <= b;
        first_of_text <= first;
        last_of_text <= last;
        do @(posedge clk); while (!in_ready);
        sb.note_word(b, first, last);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Picks a text byte, half the time from the pattern while a text is open, so that matches occur.
    function automatic logic [7:0] pick_byte(int unsigned alpha);
        int unsigned r = $urandom_range(0, 9);
        int unsigned k = $urandom_range(0, sb.plen - 1);
        if (r < 5 && sb.open)
            return sb.pat[k];
        if (r < 8)
            return 8'($urandom_range(0, alpha));
        return 8'($urandom);
    endfunction

    // A text that may embed the pattern somewhere inside.
    task automatic send_text(int unsigned len, int unsigned alpha, bit paced);
        int unsigned at;
        int unsigned n;
        logic [7:0] b;
        at = $urandom_range(0, len);
        n = 0;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                b = 8'($urandom_range(0, alpha));
            else if (i >= at && i - at < sb.plen && $urandom_range(0, 3) != 0)
                b = sb.pat[i - at];
            else
                b = pick_byte(alpha);
            send_word(b, i == 0, i == len - 1, paced);
        end
    endtask

    task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                             logic [15:0] modulus);
        write_cfg(CFG_PAT_LOW, lo);
        write_cfg(CFG_PAT_HIGH, hi);
        write_cfg(CFG_PAT_LEN, {59'd0, len});
        write_cfg(CFG_MODULUS, {48'd0, modulus});
    endtask

    initial
    begin
        int unsigned sent;
        logic [15:0] mods [6] = '{16'd101, 16'd2, 16'd65535, 16'd65521, 16'd3, 16'd257};
        sb.clear();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset pattern (one zero byte) and an implicit start; the
        // first byte matches, and a lone last byte of a new text does not.
        send_word(8'h00, 0, 0, 0);
        send_word(8'hFF, 0, 1, 0);
        send_word(8'h11, 0, 1, 0);
        drain();
        // Full sixteen-byte pattern of extreme bytes, found at position 2.
        configure(64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF, 5'd16, 16'd65535);
        send_word(8'h55, 1, 0, 0);
        for (int k = 0; k < 16; k++)
            send_word(k < 8 ? sb.reg_low[8*k +: 8] : sb.reg_high[8*(k-8) +: 8],
                      0, 0, 0);
        send_word(8'hFF, 0, 1, 0);
        // Text shorter than the pattern; a write mid-text must not apply.
        send_word(8'h00, 1, 0, 0);
        drain();
        write_cfg(CFG_PAT_LEN, 64'd0);
        send_word(8'h00, 0, 1, 0);
        drain();
        // Length zero clamps to one, length above sixteen clamps to sixteen,
        // modulus below two clamps to two.
        configure(64'h0000_0000_0000_00AB, 64'd0, 5'd0, 16'd0);
        send_word(8'hAB, 1, 0, 0);
        send_word(8'hAB, 0, 1, 0);
        drain();
        write_cfg(CFG_PAT_LEN, 64'd31);
        write_cfg(CFG_MODULUS, 64'd1);
        send_word(8'h01, 1, 1, 0);
        drain();

        // Long hold-off of the receiver while words keep coming.
        configure(64'h0302_0103, 64'd0, 5'd2, 16'd101);
        hold_off = 1;
        send_text(40, 3, 0);
        drain();

        // Random texts over several settings.
        sent = 0;
        while (sent < 1800)
        begin
            configure({$urandom, $urandom}, {$urandom, $urandom},
                      5'($urandom_range(0, 31) < 28 ? $urandom_range(1, 4)
                                                    : $urandom_range(0, 31)),
                      $urandom_range(0, 4) == 0 ? 16'($urandom_range(0, 65535))
                                                : mods[$urandom_range(0, 5)]);
            // Restrict the pattern to a small alphabet now and then.
            if ($urandom_range(0, 1) == 0)
                configure(64'h0102_0201_0001_0201 & {8{8'h03}},
                          64'h0301_0200_0103_0201, sb.reg_len, sb.reg_mod);
            for (int t = 0; t < 8; t++)
            begin
                int unsigned len;
                len = $urandom_range(1, 30);
                send_text(len, 3, $urandom_range(0, 2) != 0);
                sent += len;
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("rolling_hash_substring_search verification clean");
        else
            $display("rolling_hash_substring_search verification failed");
        $finish;
    end
endmodule
